// ----- sv/shs_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// shs_pkg
// Shared types, constants and helper functions for the Salsa20/HSalsa20 core.
// ----------------------------------------------------------------------------
package shs_pkg;

    localparam int DOUBLE_ROUNDS_DEF = 10;
    localparam int STEPS_PER_DR      = 8;

    // "expand 32-byte k" as little-endian words
    localparam logic [31:0] SIGMA0 = 32'h6170_7865;
    localparam logic [31:0] SIGMA1 = 32'h3320_646e;
    localparam logic [31:0] SIGMA2 = 32'h7962_2d32;
    localparam logic [31:0] SIGMA3 = 32'h6b20_6574;

    localparam logic [4:0] ROT_B = 5'd7;
    localparam logic [4:0] ROT_C = 5'd9;
    localparam logic [4:0] ROT_D = 5'd13;
    localparam logic [4:0] ROT_A = 5'd18;

    localparam logic [1:0] ROLE_A = 2'd0;
    localparam logic [1:0] ROLE_B = 2'd1;
    localparam logic [1:0] ROLE_C = 2'd2;
    localparam logic [1:0] ROLE_D = 2'd3;

    localparam logic OP_SALSA  = 1'b0;
    localparam logic OP_HSALSA = 1'b1;

    // Quarter-round sub-step: which word of (a, b, c, d) gets updated
    typedef enum logic [1:0] {
        SUB_B = 2'd0,
        SUB_C = 2'd1,
        SUB_D = 2'd2,
        SUB_A = 2'd3
    } t_sub;

    typedef struct packed {
        logic row;
        t_sub sub;
    } t_step;

    typedef struct packed {
        logic        op;
        logic [63:0] key_word0;
        logic [63:0] key_word1;
        logic [63:0] key_word2;
        logic [63:0] key_word3;
        logic [63:0] nonce;
        logic [63:0] counter;
    } t_in;

    typedef logic [15:0][31:0] t_state;
    typedef logic [7:0][63:0]  t_block;

    function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] amt);
        return (v << amt) | (v >> (6'd32 - {1'b0, amt}));
    endfunction

    // Word index of a quarter-round role. Column q: 5q + 4*role mod 16.
    // Row q: 4q + ((q + role) mod 4).
    function automatic logic [3:0] qr_idx(input logic row, input logic [1:0] q,
                                          input logic [1:0] role);
        logic [1:0] col;
        logic [3:0] base;
        col  = q + role;
        base = {q, 2'b00} + {2'b00, q} + {role, 2'b00};
        return row ? {q, col} : base;
    endfunction

    function automatic t_state build_init(input t_in x);
        t_state s;
        s[0]  = SIGMA0;
        s[1]  = x.key_word0[31:0];
        s[2]  = x.key_word0[63:32];
        s[3]  = x.key_word1[31:0];
        s[4]  = x.key_word1[63:32];
        s[5]  = SIGMA1;
        s[6]  = x.nonce[31:0];
        s[7]  = x.nonce[63:32];
        s[8]  = x.counter[31:0];
        s[9]  = x.counter[63:32];
        s[10] = SIGMA2;
        s[11] = x.key_word2[31:0];
        s[12] = x.key_word2[63:32];
        s[13] = x.key_word3[31:0];
        s[14] = x.key_word3[63:32];
        s[15] = SIGMA3;
        return s;
    endfunction

endpackage
`default_nettype wire

// ----- sv/shs_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// shs_in_if / shs_out_if
// Valid/ready channels for request and keystream block transactions.
// ----------------------------------------------------------------------------
interface shs_in_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [63:0] key_word0;
    logic [63:0] key_word1;
    logic [63:0] key_word2;
    logic [63:0] key_word3;
    logic [63:0] nonce;
    logic [63:0] counter;

    modport source (output valid, op, key_word0, key_word1, key_word2, key_word3,
                    nonce, counter, input ready);
    modport sink   (input valid, op, key_word0, key_word1, key_word2, key_word3,
                    nonce, counter, output ready);
endinterface

interface shs_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] block_word0;
    logic [63:0] block_word1;
    logic [63:0] block_word2;
    logic [63:0] block_word3;
    logic [63:0] block_word4;
    logic [63:0] block_word5;
    logic [63:0] block_word6;
    logic [63:0] block_word7;

    modport source (output valid, block_word0, block_word1, block_word2, block_word3,
                    block_word4, block_word5, block_word6, block_word7, input ready);
    modport sink   (input valid, block_word0, block_word1, block_word2, block_word3,
                    block_word4, block_word5, block_word6, block_word7, output ready);
endinterface
`default_nettype wire

// ----- sv/shs_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// shs_cell
// One add-rotate-xor step applied to all four quarter rounds of a column or
// row round, with a pipeline register and per-stage flow control.
// ----------------------------------------------------------------------------
module shs_cell (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire shs_pkg::t_step  i_step,
    input  wire                  i_valid,
    output logic                 o_ready,
    input  wire shs_pkg::t_in    i_in,
    input  wire shs_pkg::t_state i_w,
    output logic                 o_valid,
    input  wire                  i_ready,
    output shs_pkg::t_in         o_in,
    output shs_pkg::t_state      o_w
);

    logic            r_valid;
    shs_pkg::t_in    r_in;
    shs_pkg::t_state r_w;
    shs_pkg::t_state n_w;

    always_comb begin
        logic [3:0] ia, ib, ic, id;
        n_w = i_w;
        for (int q = 0; q < 4; q++) begin
            ia = shs_pkg::qr_idx(i_step.row, 2'(q), shs_pkg::ROLE_A);
            ib = shs_pkg::qr_idx(i_step.row, 2'(q), shs_pkg::ROLE_B);
            ic = shs_pkg::qr_idx(i_step.row, 2'(q), shs_pkg::ROLE_C);
            id = shs_pkg::qr_idx(i_step.row, 2'(q), shs_pkg::ROLE_D);
            case (i_step.sub)
                shs_pkg::SUB_B: begin
                    n_w[ib] = i_w[ib] ^ shs_pkg::rotl32(i_w[ia] + i_w[id], shs_pkg::ROT_B);
                end
                shs_pkg::SUB_C: begin
                    n_w[ic] = i_w[ic] ^ shs_pkg::rotl32(i_w[ib] + i_w[ia], shs_pkg::ROT_C);
                end
                shs_pkg::SUB_D: begin
                    n_w[id] = i_w[id] ^ shs_pkg::rotl32(i_w[ic] + i_w[ib], shs_pkg::ROT_D);
                end
                shs_pkg::SUB_A: begin
                    n_w[ia] = i_w[ia] ^ shs_pkg::rotl32(i_w[id] + i_w[ic], shs_pkg::ROT_A);
                end
                default: begin
                    n_w[ib] = i_w[ib];
                end
            endcase
        end
    end

    // stage takes new data when empty or when its contents move on
    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in <= i_in;
            r_w  <= n_w;
        end
    end

    assign o_valid = r_valid;
    assign o_in    = r_in;
    assign o_w     = r_w;

endmodule
`default_nettype wire

// ----- sv/shs_final.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// shs_final
// Feed-forward add or HSalsa20 word selection, then the output register.
// ----------------------------------------------------------------------------
module shs_final (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    output logic                 o_ready,
    input  wire shs_pkg::t_in    i_in,
    input  wire shs_pkg::t_state i_w,
    shs_out_if.source            o_out
);

    logic            r_valid;
    shs_pkg::t_block r_blk;
    shs_pkg::t_block n_blk;

    always_comb begin
        shs_pkg::t_state init;
        shs_pkg::t_state sum;
        init = shs_pkg::build_init(i_in);
        for (int k = 0; k < 16; k++) begin
            sum[k] = i_w[k] + init[k];
        end
        if (i_in.op == shs_pkg::OP_HSALSA) begin
            n_blk[0] = {i_w[5], i_w[0]};
            n_blk[1] = {i_w[15], i_w[10]};
            n_blk[2] = {i_w[7], i_w[6]};
            n_blk[3] = {i_w[9], i_w[8]};
            n_blk[4] = '0;
            n_blk[5] = '0;
            n_blk[6] = '0;
            n_blk[7] = '0;
        end else begin
            for (int m = 0; m < 8; m++) begin
                n_blk[m] = {sum[2 * m + 1], sum[2 * m]};
            end
        end
    end

    assign o_ready = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_blk <= n_blk;
        end
    end

    assign o_out.valid       = r_valid;
    assign o_out.block_word0 = r_blk[0];
    assign o_out.block_word1 = r_blk[1];
    assign o_out.block_word2 = r_blk[2];
    assign o_out.block_word3 = r_blk[3];
    assign o_out.block_word4 = r_blk[4];
    assign o_out.block_word5 = r_blk[5];
    assign o_out.block_word6 = r_blk[6];
    assign o_out.block_word7 = r_blk[7];

endmodule
`default_nettype wire

// ----- sv/salsa20_hsalsa20_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// salsa20_hsalsa20_core
// Fully pipelined Salsa20/20 block function with HSalsa20 subkey mode.
// ----------------------------------------------------------------------------
// The core accepts one request transaction per clock and delivers one 64-byte
// block per clock at full throughput while the output is not stalled. Each
// request passes through a row of 8*DOUBLE_ROUNDS registered cells, each
// doing one add-rotate-xor step of four parallel quarter rounds, followed by
// the feed-forward/output register. Every stage has its own valid bit and
// holds under backpressure, so requests keep being taken into empty stages
// while the output is stalled.
// ----------------------------------------------------------------------------
module salsa20_hsalsa20_core #(
    parameter int DOUBLE_ROUNDS = shs_pkg::DOUBLE_ROUNDS_DEF
) (
    input  wire            i_clk,
    input  wire            i_rst_n,
    shs_in_if.sink         i_in,
    shs_out_if.source      o_out
);

    localparam int NCELLS = shs_pkg::STEPS_PER_DR * DOUBLE_ROUNDS;

    logic [NCELLS:0] c_valid;
    logic [NCELLS:0] c_ready;
    shs_pkg::t_in    c_in [NCELLS+1];
    shs_pkg::t_state c_w  [NCELLS+1];

    assign c_valid[0]      = i_in.valid;
    assign c_in[0].op        = i_in.op;
    assign c_in[0].key_word0 = i_in.key_word0;
    assign c_in[0].key_word1 = i_in.key_word1;
    assign c_in[0].key_word2 = i_in.key_word2;
    assign c_in[0].key_word3 = i_in.key_word3;
    assign c_in[0].nonce     = i_in.nonce;
    assign c_in[0].counter   = i_in.counter;
    assign c_w[0]          = shs_pkg::build_init(c_in[0]);
    assign i_in.ready      = c_ready[0];

    for (genvar k = 0; k < NCELLS; k++) begin : g_cell
        shs_pkg::t_step step;
        // cells alternate four column steps and four row steps
        assign step.row = 1'((k / 4) % 2);
        assign step.sub = shs_pkg::t_sub'(2'(k % 4));

        shs_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_step  (step),
            .i_valid (c_valid[k]),
            .o_ready (c_ready[k]),
            .i_in    (c_in[k]),
            .i_w     (c_w[k]),
            .o_valid (c_valid[k+1]),
            .i_ready (c_ready[k+1]),
            .o_in    (c_in[k+1]),
            .o_w     (c_w[k+1])
        );
    end

    shs_final u_final (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (c_valid[NCELLS]),
        .o_ready (c_ready[NCELLS]),
        .i_in    (c_in[NCELLS]),
        .i_w     (c_w[NCELLS]),
        .o_out   (o_out)
    );

`ifndef ASSERT_OFF
    a_accept_fills_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> c_valid[1])
        else $error("accepted request did not enter the first cell");

    a_busy_means_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> c_valid[1])
        else $error("input stalled while first cell is empty");

    a_last_to_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (c_valid[NCELLS] && c_ready[NCELLS]) |=> o_out.valid)
        else $error("block from last cell did not reach the output register");

    a_last_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (c_valid[NCELLS] && !c_ready[NCELLS]) |=> (c_valid[NCELLS] && $stable(c_w[NCELLS])))
        else $error("last cell lost or changed its state while stalled");
`endif

endmodule
`default_nettype wire
